/* rtl/sumo_fsm_pkg.sv */
// types and constants shared by the sumo behaviour controller
package sumo_fsm_pkg;

    typedef enum logic [3:0] {
        MODE_START   = 4'd0,
        MODE_SEARCH  = 4'd1,
        MODE_ALIGN   = 4'd2,
        MODE_ADVANCE = 4'd3,
        MODE_ATTACK  = 4'd4,
        MODE_LINE    = 4'd5,
        MODE_TURN180 = 4'd6,
        MODE_RIGHT90 = 4'd7,
        MODE_LEFT90  = 4'd8
    } mode_t;

    typedef enum logic [2:0] {
        CMD_HOLD  = 3'd0,
        CMD_FWD   = 3'd1,
        CMD_BACK  = 3'd2,
        CMD_LEFT  = 3'd3,
        CMD_RIGHT = 3'd4,
        CMD_STOP  = 3'd5
    } cmd_t;

    localparam logic [6:0] LINE_BACK_POWER = 7'd20;
    localparam logic [6:0] STOP_ARG        = 7'd60;

    typedef struct packed {
        logic [15:0] search_half_period;
        logic [15:0] line_window;
        logic [15:0] turn_half_circle_time;
        logic [6:0]  power_search_forward;
        logic [6:0]  power_search_backward;
        logic [6:0]  power_turn;
        logic [6:0]  power_advance;
        logic [6:0]  power_attack;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic [6:0]  enemy_bits;
        logic [1:0]  line_bits;
    } item_t;

    typedef struct packed {
        mode_t      mode;
        cmd_t       motor_cmd;
        logic [6:0] motor_power;
    } result_t;

endpackage

/* rtl/sumo_fsm_cfg.sv */
// apb register file holding the timing and power settings
module sumo_fsm_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output sumo_fsm_pkg::cfg_t   cfg
);

    typedef enum logic [2:0] {
        REG_SEARCH_HALF  = 3'd0,
        REG_LINE_WINDOW  = 3'd1,
        REG_TURN_HALF    = 3'd2,
        REG_PWR_SRCH_FWD = 3'd3,
        REG_PWR_SRCH_BCK = 3'd4,
        REG_PWR_TURN     = 3'd5,
        REG_PWR_ADVANCE  = 3'd6,
        REG_PWR_ATTACK   = 3'd7
    } reg_idx_t;

    sumo_fsm_pkg::cfg_t cfg_reg;
    reg_idx_t           idx;
    logic               wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.search_half_period    <= 16'd1000;
            cfg_reg.line_window           <= 16'd200;
            cfg_reg.turn_half_circle_time <= 16'd500;
            cfg_reg.power_search_forward  <= 7'd50;
            cfg_reg.power_search_backward <= 7'd50;
            cfg_reg.power_turn            <= 7'd50;
            cfg_reg.power_advance         <= 7'd60;
            cfg_reg.power_attack          <= 7'd100;
        end else if (wr_en) begin
            unique case (idx)
                REG_SEARCH_HALF:  cfg_reg.search_half_period    <= pwdata[15:0];
                REG_LINE_WINDOW:  cfg_reg.line_window           <= pwdata[15:0];
                REG_TURN_HALF:    cfg_reg.turn_half_circle_time <= pwdata[15:0];
                REG_PWR_SRCH_FWD: cfg_reg.power_search_forward  <= pwdata[6:0];
                REG_PWR_SRCH_BCK: cfg_reg.power_search_backward <= pwdata[6:0];
                REG_PWR_TURN:     cfg_reg.power_turn            <= pwdata[6:0];
                REG_PWR_ADVANCE:  cfg_reg.power_advance         <= pwdata[6:0];
                REG_PWR_ATTACK:   cfg_reg.power_attack          <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SEARCH_HALF:  prdata = {16'd0, cfg_reg.search_half_period};
            REG_LINE_WINDOW:  prdata = {16'd0, cfg_reg.line_window};
            REG_TURN_HALF:    prdata = {16'd0, cfg_reg.turn_half_circle_time};
            REG_PWR_SRCH_FWD: prdata = {25'd0, cfg_reg.power_search_forward};
            REG_PWR_SRCH_BCK: prdata = {25'd0, cfg_reg.power_search_backward};
            REG_PWR_TURN:     prdata = {25'd0, cfg_reg.power_turn};
            REG_PWR_ADVANCE:  prdata = {25'd0, cfg_reg.power_advance};
            REG_PWR_ATTACK:   prdata = {25'd0, cfg_reg.power_attack};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/sumo_fsm_core.sv */
// behaviour state machine: mode and timer registers plus next-state logic
module sumo_fsm_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  sumo_fsm_pkg::item_t     item,
    input  sumo_fsm_pkg::cfg_t      cfg,
    output sumo_fsm_pkg::result_t   result
);

    typedef sumo_fsm_pkg::mode_t mode_t;

    mode_t       mode_reg, mode_next;
    logic [31:0] search_start_reg, search_start_next;
    logic [31:0] turn_start_reg, turn_start_next;
    logic [31:0] line_start_reg, line_start_next;

    sumo_fsm_pkg::cmd_t cmd;
    logic [6:0]         pw;

    logic [31:0] dt_search, dt_line, dt_turn;
    logic        front, both_front, left, right, side_or_front, rear, l0, l1;

    assign front         = |item.enemy_bits[3:2];
    assign both_front    = &item.enemy_bits[3:2];
    assign left          = |item.enemy_bits[1:0];
    assign right         = |item.enemy_bits[5:4];
    assign side_or_front = |item.enemy_bits[5:0];
    assign rear          = item.enemy_bits[6];
    assign l0            = item.line_bits[0];
    assign l1            = item.line_bits[1];

    // wrapping elapsed times
    assign dt_search = item.now_ms - search_start_reg;
    assign dt_line   = item.now_ms - line_start_reg;
    assign dt_turn   = item.now_ms - turn_start_reg;

    always_comb begin
        mode_next         = mode_reg;
        search_start_next = search_start_reg;
        turn_start_next   = turn_start_reg;
        line_start_next   = line_start_reg;
        cmd               = sumo_fsm_pkg::CMD_HOLD;
        pw                = 7'd0;
        if (item.action) begin
            mode_next = sumo_fsm_pkg::MODE_START;
            cmd       = sumo_fsm_pkg::CMD_STOP;
            pw        = sumo_fsm_pkg::STOP_ARG;
        end else begin
            unique case (mode_reg)
                sumo_fsm_pkg::MODE_START, sumo_fsm_pkg::MODE_SEARCH: begin
                    if (mode_reg == sumo_fsm_pkg::MODE_SEARCH) begin
                        if (dt_search < {16'd0, cfg.search_half_period}) begin
                            cmd = sumo_fsm_pkg::CMD_FWD;
                            pw  = cfg.power_search_forward;
                        end else if (dt_search < {15'd0, cfg.search_half_period, 1'b0}) begin
                            cmd = sumo_fsm_pkg::CMD_BACK;
                            pw  = cfg.power_search_backward;
                        end else begin
                            search_start_next = item.now_ms;
                        end
                    end
                    if (l0 || l1) begin
                        mode_next       = sumo_fsm_pkg::MODE_LINE;
                        line_start_next = item.now_ms;
                    end else if (side_or_front) begin
                        mode_next = sumo_fsm_pkg::MODE_ALIGN;
                    end else if (rear) begin
                        mode_next       = sumo_fsm_pkg::MODE_TURN180;
                        turn_start_next = item.now_ms;
                    end else if (mode_reg == sumo_fsm_pkg::MODE_START) begin
                        mode_next         = sumo_fsm_pkg::MODE_SEARCH;
                        search_start_next = item.now_ms;
                    end
                end
                sumo_fsm_pkg::MODE_ALIGN: begin
                    if (front) begin
                        mode_next = sumo_fsm_pkg::MODE_ADVANCE;
                    end else if (left) begin
                        cmd = sumo_fsm_pkg::CMD_LEFT;
                        pw  = cfg.power_turn;
                    end else if (right) begin
                        cmd = sumo_fsm_pkg::CMD_RIGHT;
                        pw  = cfg.power_turn;
                    end else begin
                        mode_next = sumo_fsm_pkg::MODE_START;
                    end
                end
                sumo_fsm_pkg::MODE_ADVANCE: begin
                    if (front) begin
                        cmd = sumo_fsm_pkg::CMD_FWD;
                        pw  = cfg.power_advance;
                        if (both_front) begin
                            mode_next = sumo_fsm_pkg::MODE_ATTACK;
                        end
                    end else begin
                        mode_next = sumo_fsm_pkg::MODE_ALIGN;
                    end
                end
                sumo_fsm_pkg::MODE_ATTACK: begin
                    cmd = sumo_fsm_pkg::CMD_FWD;
                    pw  = cfg.power_attack;
                    if (!both_front) begin
                        mode_next = sumo_fsm_pkg::MODE_START;
                    end
                end
                sumo_fsm_pkg::MODE_LINE: begin
                    if (dt_line < {16'd0, cfg.line_window}) begin
                        if (l0 && l1) begin
                            cmd             = sumo_fsm_pkg::CMD_BACK;
                            pw              = sumo_fsm_pkg::LINE_BACK_POWER;
                            mode_next       = sumo_fsm_pkg::MODE_TURN180;
                            turn_start_next = item.now_ms;
                        end else if (l0) begin
                            mode_next       = sumo_fsm_pkg::MODE_RIGHT90;
                            turn_start_next = item.now_ms;
                        end else if (l1) begin
                            mode_next       = sumo_fsm_pkg::MODE_LEFT90;
                            turn_start_next = item.now_ms;
                        end
                    end else begin
                        mode_next = sumo_fsm_pkg::MODE_START;
                    end
                end
                sumo_fsm_pkg::MODE_TURN180: begin
                    if (dt_turn < {16'd0, cfg.turn_half_circle_time}) begin
                        cmd = sumo_fsm_pkg::CMD_RIGHT;
                        pw  = cfg.power_turn;
                    end else begin
                        mode_next = sumo_fsm_pkg::MODE_START;
                    end
                end
                sumo_fsm_pkg::MODE_RIGHT90: begin
                    if (dt_turn < {17'd0, cfg.turn_half_circle_time[15:1]}) begin
                        cmd = sumo_fsm_pkg::CMD_RIGHT;
                        pw  = cfg.power_turn;
                    end else begin
                        mode_next = sumo_fsm_pkg::MODE_START;
                    end
                end
                sumo_fsm_pkg::MODE_LEFT90: begin
                    if (dt_turn < {17'd0, cfg.turn_half_circle_time[15:1]}) begin
                        cmd = sumo_fsm_pkg::CMD_LEFT;
                        pw  = cfg.power_turn;
                    end else begin
                        mode_next = sumo_fsm_pkg::MODE_START;
                    end
                end
                default: begin
                    mode_next = sumo_fsm_pkg::MODE_START;
                end
            endcase
        end
    end

    assign result.mode        = mode_next;
    assign result.motor_cmd   = cmd;
    assign result.motor_power = pw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= sumo_fsm_pkg::MODE_START;
            search_start_reg <= 32'd0;
            turn_start_reg   <= 32'd0;
            line_start_reg   <= 32'd0;
        end else if (step) begin
            mode_reg         <= mode_next;
            search_start_reg <= search_start_next;
            turn_start_reg   <= turn_start_next;
            line_start_reg   <= line_start_next;
        end
    end

endmodule

/* rtl/sumo_robot_behaviour_fsm_unit.sv */
// top level of the sumo behaviour controller: input register, state machine, result register
// Takes one update or stop word per clock while m_ready holds and returns one result word
// for each, in order. A word is accepted into the input register, and its result is written
// to the result register as the word leaves it; a full result register that is not taken
// holds it back. The sustained rate is one word per cycle while m_ready holds: the state
// machine and its three wrapping 32-bit timers advance as a word leaves the input register.
// Each result carries the new mode and one motor command with its power. Timing and power
// settings sit in an APB register file at byte addresses 4*i and should be changed only
// while no word is in flight.
module sumo_robot_behaviour_fsm_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_now_ms,
    input  logic [6:0]  s_enemy_bits,
    input  logic [1:0]  s_line_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_mode,
    output logic [2:0]  m_motor_cmd,
    output logic [6:0]  m_motor_power,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sumo_fsm_pkg::cfg_t    cfg;
    sumo_fsm_pkg::item_t   in_reg;
    sumo_fsm_pkg::result_t res;
    sumo_fsm_pkg::result_t out_reg;
    logic                  in_valid_reg;
    logic                  out_valid_reg;
    logic                  advance;
    logic                  step;

    // result register free, or emptying this cycle
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    sumo_fsm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sumo_fsm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.action     <= s_action;
            in_reg.now_ms     <= s_now_ms;
            in_reg.enemy_bits <= s_enemy_bits;
            in_reg.line_bits  <= s_line_bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_mode        = out_reg.mode;
    assign m_motor_cmd   = out_reg.motor_cmd;
    assign m_motor_power = out_reg.motor_power;

endmodule
